// File: sv/quartic_newton_root_finder_macros.svh
// Assertion macros for the quartic Newton root finder.
`ifndef QUARTIC_NEWTON_ROOT_FINDER_MACROS_SVH
`define QUARTIC_NEWTON_ROOT_FINDER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define QNR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define QNR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: sv/qnr_pkg.sv
// Shared types and constants of the quartic Newton root finder.
package qnr_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int SCAN_STEP_DEF = 655;
	localparam int MAX_SCAN_STEPS_DEF = 4096;

	localparam logic [2:0] ST_CONVERGED = 3'd0;
	localparam logic [2:0] ST_NOT_ISOLATING = 3'd1;
	localparam logic [2:0] ST_ITER_LIMIT = 3'd2;
	localparam logic [2:0] ST_ZERO_DERIV = 3'd3;
	localparam logic [2:0] ST_SCAN_LIMIT = 3'd4;

	localparam logic [2:0] REG_COEF_0 = 3'd0;
	localparam logic [2:0] REG_COEF_1 = 3'd1;
	localparam logic [2:0] REG_COEF_2 = 3'd2;
	localparam logic [2:0] REG_COEF_3 = 3'd3;
	localparam logic [2:0] REG_COEF_4 = 3'd4;
	localparam logic [2:0] REG_TOL = 3'd5;
	localparam logic [2:0] REG_LIMIT = 3'd6;

	// Polynomial selected for a Horner evaluation.
	typedef enum logic [1:0] {
		POLY_F,
		POLY_D1,
		POLY_D2
	} poly_t;

	// Destination register of a finished evaluation.
	typedef enum logic [3:0] {
		DST_FLO,
		DST_FHI,
		DST_SA,
		DST_SB,
		DST_MA,
		DST_MB,
		DST_D2,
		DST_D,
		DST_FX0,
		DST_FX1
	} dst_t;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_EVAL,
		OP_STEP,
		OP_ERR,
		OP_ZNEXT,
		OP_PICK
	} op_t;

	typedef struct packed {
		logic  start;
		op_t   op;
		poly_t poly;
		dst_t  dst;
		logic [1:0] xsel;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic bad_order;
		logic scan_over;
		logic ends_same;
		logic scan_bad;
		logic z_done;
		logic m_zero;
		logic d_zero;
		logic err_ok;
	} sts_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LOAD,
		S_CHK,
		S_FLO,
		S_FHI,
		S_ENDS,
		S_SA,
		S_SB,
		S_SCHK,
		S_MA,
		S_MB,
		S_D2,
		S_PICK,
		S_D,
		S_DCHK,
		S_FX0,
		S_STEP,
		S_FX1,
		S_ERR,
		S_ECHK,
		S_OUT
	} state_t;

	localparam logic [1:0] X_LO = 2'd0;
	localparam logic [1:0] X_HI = 2'd1;
	localparam logic [1:0] X_Z = 2'd2;
	localparam logic [1:0] X_X0 = 2'd3;
	localparam logic [1:0] X_ZS = 2'd3;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

// File: sv/quartic_newton_root_finder.sv
// Top level of the quartic Newton root finder.
// Each transaction takes an interval and returns one root, iteration count and status.
// A Horner evaluation alternates a multiply and an add per coefficient on one shared 32x32
// multiplier, and each division runs on a radix-2 divider; a transaction evaluates two
// samples for the first derivative scan point and one for each later one, plus three
// evaluations and two divisions per Newton iteration; inputs are taken one at a time.
module quartic_newton_root_finder import qnr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SCAN_STEP = SCAN_STEP_DEF,
	parameter int MAX_SCAN_STEPS = MAX_SCAN_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] interval_low,
	input  logic signed [31:0] interval_high,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] root,
	output logic [7:0]         iterations,
	output logic [2:0]         status
);
	cmd_t cmd;
	sts_t sts;
	logic zr;
	logic signed [31:0] x0;
	logic [7:0] lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lim_q <= 8'd64;
		else if (cfg_we && cfg_index == REG_LIMIT) lim_q <= cfg_data[7:0];
	end

	qnr_datapath #(.FRAC_BITS(FRAC_BITS), .SCAN_STEP(SCAN_STEP),
		.MAX_SCAN_STEPS(MAX_SCAN_STEPS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .cfg_we(cfg_we),
		.cfg_idx(cfg_index), .cfg_data(cfg_data), .in_low(interval_low),
		.in_high(interval_high), .x0_out(x0)
	);

	qnr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .limit(lim_q), .sts(sts),
		.cmd(cmd), .zero_root(zr), .iter_count(iterations), .status_code(status)
	);

	assign root = zr ? 32'sd0 : x0;
endmodule

// File: sv/qnr_divider.sv
// Radix-2 restoring divider for 64-bit unsigned magnitudes.
module qnr_divider import qnr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	logic [63:0] rem_q, quo_q, den_q;
	logic [6:0] cnt_q;
	logic run_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (run_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

// File: sv/qnr_datapath.sv
// Datapath: Horner evaluator, scan point, Newton step and error check.
module qnr_datapath import qnr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SCAN_STEP = SCAN_STEP_DEF,
	parameter int MAX_SCAN_STEPS = MAX_SCAN_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_data,
	input  logic signed [31:0] in_low,
	input  logic signed [31:0] in_high,
	output logic signed [31:0] x0_out
);
	logic signed [31:0] c0_q, c1_q, c2_q, c3_q, c4_q;
	logic [30:0] tol_q;
	logic signed [31:0] lo_q, hi_q, z_q, x0_q;
	logic signed [31:0] flo_q, fhi_q, sa_q, sb_q, d2_q, d_q, fx0_q, fx1_q;
	logic [31:0] m_q, ma_q, mb_q;
	logic signed [31:0] acc_q, xe_q;
	logic [2:0] hstep_q, hlen_q;
	logic hrun_q, mrun_q;
	logic signed [63:0] prod_q;
	dst_t dst_q;
	poly_t poly_q;
	logic div_start, div_done, div_busy_q, div_neg_q;
	logic [63:0] div_a, div_b, div_qt;
	op_t div_op_q;
	logic [32:0] span;
	logic signed [33:0] zs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c0_q <= '0; c1_q <= '0; c2_q <= '0; c3_q <= '0; c4_q <= '0;
			tol_q <= 31'd66;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_COEF_0: c0_q <= cfg_data;
				REG_COEF_1: c1_q <= cfg_data;
				REG_COEF_2: c2_q <= cfg_data;
				REG_COEF_3: c3_q <= cfg_data;
				REG_COEF_4: c4_q <= cfg_data;
				REG_TOL:    tol_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	function automatic logic signed [31:0] coef_at(poly_t p, logic [2:0] k,
		logic signed [31:0] a0, logic signed [31:0] a1, logic signed [31:0] a2,
		logic signed [31:0] a3, logic signed [31:0] a4);
		logic signed [65:0] r;
		r = '0;
		case (p)
			POLY_F: begin
				case (k)
					3'd0: r = 66'(a4);
					3'd1: r = 66'(a3);
					3'd2: r = 66'(a2);
					3'd3: r = 66'(a1);
					default: r = 66'(a0);
				endcase
			end
			POLY_D1: begin
				case (k)
					3'd0: r = 66'(a4) * 66'sd4;
					3'd1: r = 66'(a3) * 66'sd3;
					3'd2: r = 66'(a2) * 66'sd2;
					default: r = 66'(a1);
				endcase
			end
			default: begin
				case (k)
					3'd0: r = 66'(a4) * 66'sd12;
					3'd1: r = 66'(a3) * 66'sd6;
					default: r = 66'(a2) * 66'sd2;
				endcase
			end
		endcase
		return sat32(r);
	endfunction

	logic signed [31:0] cnext;
	logic signed [65:0] hsum;
	assign cnext = coef_at(poly_q, hstep_q, c0_q, c1_q, c2_q, c3_q, c4_q);
	assign hsum = 66'(prod_q >>> FRAC_BITS) + 66'(cnext);
	assign zs = 34'(z_q) + 34'(SCAN_STEP);
	assign span = 33'(hi_q) - 33'(lo_q);

	logic signed [31:0] xsrc;
	always_comb begin
		case (cmd.xsel)
			X_LO: xsrc = lo_q;
			X_HI: xsrc = hi_q;
			X_Z:  xsrc = z_q;
			default: xsrc = (cmd.dst == DST_SB) ? sat32(66'(zs)) : x0_q;
		endcase
	end

	logic signed [31:0] hres;
	logic hfin;
	assign hres = sat32(hsum);
	assign hfin = hrun_q && !mrun_q && hstep_q == hlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hrun_q <= 1'b0;
			mrun_q <= 1'b0;
			hstep_q <= '0;
		end else if (cmd.start && cmd.op == OP_EVAL) begin
			hrun_q <= 1'b1;
			mrun_q <= 1'b1;
			hstep_q <= 3'd1;
		end else if (hrun_q) begin
			mrun_q <= !mrun_q;
			if (hfin) hrun_q <= 1'b0;
			else if (!mrun_q) hstep_q <= hstep_q + 3'd1;
		end
	end

	logic [31:0] absr;
	assign absr = hres[31] ? 32'(-hres) : hres;

	always_ff @(posedge clk) begin
		if (cmd.start && cmd.op == OP_EVAL) begin
			xe_q <= xsrc;
			dst_q <= cmd.dst;
			poly_q <= cmd.poly;
			hlen_q <= (cmd.poly == POLY_F) ? 3'd4 : (cmd.poly == POLY_D1) ? 3'd3 : 3'd2;
			acc_q <= coef_at(cmd.poly, 3'd0, c0_q, c1_q, c2_q, c3_q, c4_q);
		end else if (hrun_q) begin
			if (mrun_q) prod_q <= 64'(acc_q) * 64'(xe_q);
			else acc_q <= hres;
		end
		if (hfin) begin
			case (dst_q)
				DST_FLO: flo_q <= hres;
				DST_FHI: fhi_q <= hres;
				DST_SA:  sa_q <= hres;
				DST_SB:  sb_q <= hres;
				DST_MA:  ma_q <= absr;
				DST_MB:  mb_q <= absr;
				DST_D2:  d2_q <= hres;
				DST_D:   d_q <= hres;
				DST_FX0: fx0_q <= hres;
				default: fx1_q <= hres;
			endcase
		end
		if (cmd.start && cmd.op == OP_LOAD) begin
			lo_q <= in_low;
			hi_q <= in_high;
			z_q <= in_low;
		end
		if (cmd.start && cmd.op == OP_ZNEXT) z_q <= sat32(66'(zs));
		if (cmd.start && cmd.op == OP_PICK) begin
			m_q <= (ma_q < mb_q) ? ma_q : mb_q;
			x0_q <= (d2_q > 0) ? lo_q : hi_q;
		end
		if (div_done && div_op_q == OP_STEP)
			x0_q <= sat32(66'(x0_q) - (div_neg_q ? -66'(div_qt) : 66'(div_qt)));
	end

	logic [63:0] fx0_mag, d_mag, fx1_mag;
	assign fx0_mag = fx0_q[31] ? 64'(-65'(fx0_q)) : 64'(fx0_q);
	assign d_mag = d_q[31] ? 64'(-65'(d_q)) : 64'(d_q);
	assign fx1_mag = fx1_q[31] ? 64'(-65'(fx1_q)) : 64'(fx1_q);
	assign div_start = cmd.start && (cmd.op == OP_STEP || cmd.op == OP_ERR);
	assign div_a = (cmd.op == OP_STEP ? fx0_mag : fx1_mag) << FRAC_BITS;
	assign div_b = (cmd.op == OP_STEP) ? d_mag : 64'(m_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
		end else if (div_start) begin
			div_busy_q <= 1'b1;
		end else if (div_done) begin
			div_busy_q <= 1'b0;
		end
	end

	logic err_ok_q;
	always_ff @(posedge clk) begin
		if (div_start) begin
			div_op_q <= cmd.op;
			div_neg_q <= fx0_q[31] ^ d_q[31];
		end
		if (div_done && div_op_q == OP_ERR) err_ok_q <= div_qt <= 64'(tol_q);
	end

	qnr_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(div_qt)
	);

	localparam logic [32:0] SCAN_SPAN = 33'(64'(MAX_SCAN_STEPS) * 64'(SCAN_STEP));

	always_comb begin
		sts.busy = hrun_q || div_busy_q;
		sts.bad_order = lo_q >= hi_q;
		sts.scan_over = span > SCAN_SPAN;
		sts.ends_same = !((flo_q[31] && fhi_q > 0) || (fhi_q[31] && flo_q > 0));
		sts.scan_bad = !((sa_q[31] && sb_q[31]) || (sa_q > 0 && sb_q > 0));
		sts.z_done = zs >= 34'(hi_q);
		sts.m_zero = m_q == '0;
		sts.d_zero = d_q == '0;
		sts.err_ok = err_ok_q;
	end

	assign x0_out = x0_q;
endmodule

// File: sv/qnr_ctrl.sv
// Controller state machine sequencing the check, scan and Newton loop.
module qnr_ctrl import qnr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] limit,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       zero_root,
	output logic [7:0] iter_count,
	output logic [2:0] status_code
);
	`include "quartic_newton_root_finder_macros.svh"
	state_t state_q, state_d;
	logic [7:0] t_q;
	logic [2:0] st_q;
	logic zr_q;
	logic [7:0] lim;
	assign lim = (limit == 8'd0) ? 8'd1 : limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	logic wait_ok;
	assign wait_ok = !sts.busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_LOAD;
			S_LOAD: state_d = S_CHK;
			S_CHK:  state_d = (sts.bad_order || sts.scan_over) ? S_OUT : S_FLO;
			S_FLO:  if (wait_ok) state_d = S_FHI;
			S_FHI:  if (wait_ok) state_d = S_ENDS;
			S_ENDS: if (wait_ok) state_d = sts.ends_same ? S_OUT : S_SA;
			S_SA:   if (wait_ok) state_d = S_SB;
			S_SB:   if (wait_ok) state_d = S_SCHK;
			S_SCHK: if (wait_ok) state_d = sts.scan_bad ? S_OUT : (sts.z_done ? S_MA : S_SA);
			S_MA:   if (wait_ok) state_d = S_MB;
			S_MB:   if (wait_ok) state_d = S_D2;
			S_D2:   if (wait_ok) state_d = S_PICK;
			S_PICK: state_d = S_DCHK;
			S_DCHK: state_d = sts.m_zero ? S_OUT : S_D;
			S_D:    if (wait_ok) state_d = S_FX0;
			S_FX0:  if (wait_ok) state_d = sts.d_zero ? S_OUT : S_STEP;
			S_STEP: if (wait_ok) state_d = S_FX1;
			S_FX1:  if (wait_ok) state_d = S_ERR;
			S_ERR:  if (wait_ok) state_d = S_ECHK;
			S_ECHK: if (wait_ok) state_d = (sts.err_ok || t_q == lim) ? S_OUT : S_D;
			S_OUT:  if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	logic entering;
	assign entering = state_d != state_q;

	always_comb begin
		cmd = '{start: 1'b0, op: OP_EVAL, poly: POLY_F, dst: DST_FLO, xsel: X_LO};
		in_ready = state_q == S_IDLE;
		out_valid = state_q == S_OUT;
		if (!sts.busy || state_q == S_LOAD || state_q == S_PICK) begin
			case (state_d)
				S_LOAD: cmd = '{1'b1, OP_LOAD, POLY_F, DST_FLO, X_LO};
				S_FLO:  cmd = '{1'b1, OP_EVAL, POLY_F, DST_FLO, X_LO};
				S_FHI:  cmd = '{1'b1, OP_EVAL, POLY_F, DST_FHI, X_HI};
				S_SA:   cmd = '{1'b1, OP_EVAL, POLY_D1, DST_SA, X_Z};
				S_SB:   cmd = '{1'b1, OP_EVAL, POLY_D1, DST_SB, X_ZS};
				S_MA:   cmd = '{1'b1, OP_EVAL, POLY_D1, DST_MA, X_LO};
				S_MB:   cmd = '{1'b1, OP_EVAL, POLY_D1, DST_MB, X_HI};
				S_D2:   cmd = '{1'b1, OP_EVAL, POLY_D2, DST_D2, X_LO};
				S_PICK: cmd = '{1'b1, OP_PICK, POLY_F, DST_FLO, X_LO};
				S_D:    cmd = '{1'b1, OP_EVAL, POLY_D1, DST_D, X_X0};
				S_FX0:  cmd = '{1'b1, OP_EVAL, POLY_F, DST_FX0, X_X0};
				S_STEP: cmd = '{1'b1, OP_STEP, POLY_F, DST_FLO, X_LO};
				S_FX1:  cmd = '{1'b1, OP_EVAL, POLY_F, DST_FX1, X_X0};
				S_ERR:  cmd = '{1'b1, OP_ERR, POLY_F, DST_FLO, X_LO};
				default: ;
			endcase
			if (state_q == S_SCHK && state_d == S_SA) cmd.op = OP_ZNEXT;
			if (state_q == S_SCHK && state_d == S_SA) cmd.start = 1'b1;
			if (!entering) cmd.start = 1'b0;
		end
	end

	// Later scan points skip the first-sample evaluation, since it equals the previous
	// second sample whose sign already passed. Only the advance is issued on leaving the check.

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= '0;
			st_q <= ST_CONVERGED;
			zr_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin t_q <= '0; zr_q <= 1'b1; st_q <= ST_NOT_ISOLATING; end
				S_CHK: if (!sts.bad_order && sts.scan_over) st_q <= ST_SCAN_LIMIT;
				S_DCHK: begin zr_q <= 1'b0; st_q <= ST_ZERO_DERIV; end
				S_STEP: if (wait_ok) t_q <= t_q + 8'd1;
				S_ECHK: if (wait_ok) st_q <= sts.err_ok ? ST_CONVERGED : ST_ITER_LIMIT;
				S_D: if (wait_ok) st_q <= ST_ZERO_DERIV;
				default: ;
			endcase
		end
	end

	assign zero_root = zr_q;
	assign iter_count = t_q;
	assign status_code = st_q;

	`QNR_ASSERT_IMP(a_ready_idle, in_ready, !out_valid)
	`QNR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`QNR_ASSERT_IMP(a_iter_bound, out_valid, iter_count <= lim)
endmodule
